// ===== src/feedback_fractional_delay_line_assert.svh =====
// Assertion macros shared by the delay line RTL.
// Define NO_ASSERTIONS to compile every macro to nothing.
`ifndef FEEDBACK_FRACTIONAL_DELAY_LINE_ASSERT_SVH
`define FEEDBACK_FRACTIONAL_DELAY_LINE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define FFDL_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);
`define FFDL_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);
`else
`define FFDL_ASSERT(lbl, clk, rst_n, prop, msg)
`define FFDL_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ===== src/ffdl_pkg.sv =====
// Shared constants for the feedback fractional delay line.
// No dependencies; used by ffdl_store, the top level and the testbench.
package ffdl_pkg;

  localparam int DEPTH_DEF         = 4096;
  localparam int FRACTION_BITS_DEF = 8;
  localparam int SAMPLE_BITS_DEF   = 24;

  // fixed field widths
  localparam int DELAY_BITS = 20;
  localparam int GAIN_BITS  = 16;
  localparam int GAIN_FRAC  = 15;

endpackage

// ===== src/ffdl_store.sv =====
// Sample store: one write port, two registered read ports.
// Entries not yet written since reset read as zero (fill tracking). Uses ffdl_pkg.
module ffdl_store #(
  parameter int DEPTH       = ffdl_pkg::DEPTH_DEF,
  parameter int SAMPLE_BITS = ffdl_pkg::SAMPLE_BITS_DEF,
  localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   rd_en_i,
  input  logic [AW-1:0]          rd_addr_a_i,
  input  logic [AW-1:0]          rd_addr_b_i,
  input  logic                   wr_en_i,
  input  logic [AW-1:0]          wr_addr_i,
  input  logic [SAMPLE_BITS-1:0] wr_data_i,
  output logic [SAMPLE_BITS-1:0] rd_data_a_o,
  output logic [SAMPLE_BITS-1:0] rd_data_b_o
);

  logic [SAMPLE_BITS-1:0] mem_q [DEPTH];
  logic [SAMPLE_BITS-1:0] rd_a_q, rd_b_q;
  logic                   val_a_q, val_b_q, val_a_d, val_b_d;
  logic                   full_q, full_d;

  // writes run in address order from zero, so below the write address
  // (or once wrapped) an entry has been written
  assign val_a_d = full_q || (rd_addr_a_i < wr_addr_i);
  assign val_b_d = full_q || (rd_addr_b_i < wr_addr_i);
  assign full_d  = full_q || (wr_en_i && (wr_addr_i == AW'(DEPTH - 1)));

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_a_q <= mem_q[rd_addr_a_i];
      rd_b_q <= mem_q[rd_addr_b_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q  <= 1'b0;
      val_a_q <= 1'b0;
      val_b_q <= 1'b0;
    end else begin
      full_q <= full_d;
      if (rd_en_i) begin
        val_a_q <= val_a_d;
        val_b_q <= val_b_d;
      end
    end
  end

  assign rd_data_a_o = val_a_q ? rd_a_q : '0;
  assign rd_data_b_o = val_b_q ? rd_b_q : '0;

endmodule

// ===== src/feedback_fractional_delay_line.sv =====
// Channel  | Dir | Word (lowest bit first)
// s_axis   | in  | in_sample[SB], delay_amount[20], zero pad to bytes
// m_axis   | out | delayed_sample[SB], zero pad to bytes
// cfg      | in  | feedback_gain[16]
//
// A word passes the delay reduction steps, a read of two store entries and
// two passes through one multiplier before its result is registered with the
// store write; the next word is taken only once the block is back in idle.
// s_axis_tready is high only while idle. A held result stalls the store
// write until m_axis takes it. Reset clears position, gain and fill
// tracking; the store reads zero until written.
// Depends on ffdl_pkg, ffdl_store and the assertion header.
`include "feedback_fractional_delay_line_assert.svh"

module feedback_fractional_delay_line #(
  parameter int DEPTH         = ffdl_pkg::DEPTH_DEF,
  parameter int FRACTION_BITS = ffdl_pkg::FRACTION_BITS_DEF,
  parameter int SAMPLE_BITS   = ffdl_pkg::SAMPLE_BITS_DEF,
  localparam int IN_W  = ((SAMPLE_BITS + ffdl_pkg::DELAY_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [IN_W-1:0]                s_axis_tdata,  // in_sample, delay_amount
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [OUT_W-1:0]               m_axis_tdata,  // delayed_sample
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ffdl_pkg::GAIN_BITS-1:0] cfg_data_i     // feedback_gain
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SB   = SAMPLE_BITS;
  localparam int FB   = FRACTION_BITS;
  localparam int DB   = ffdl_pkg::DELAY_BITS;
  localparam int IPW  = DB - FB;
  localparam int CW   = ((IPW > AW) ? IPW : AW) + 1;
  localparam int KMAX = (IPW > AW) ? IPW - AW : 0;
  localparam int KW   = (KMAX > 0) ? $clog2(KMAX + 1) : 1;
  localparam int MA   = SB + 1;
  localparam int MB   = (FB + 1 > ffdl_pkg::GAIN_BITS) ? FB + 1 : ffdl_pkg::GAIN_BITS;
  localparam int PW   = MA + MB;

  localparam logic signed [PW-1:0] RND_Y  = PW'(1) << (FB - 1);
  localparam logic signed [PW-1:0] RND_FB = PW'(1) << (ffdl_pkg::GAIN_FRAC - 1);
  localparam logic signed [SB+1:0] SMAX   = (SB + 2)'((64'd1 << (SB - 1)) - 64'd1);
  localparam logic signed [SB+1:0] SMIN   = -SMAX - 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RED  = 3'd1;
  localparam logic [2:0] ST_ADDR = 3'd2;
  localparam logic [2:0] ST_MUL1 = 3'd3;
  localparam logic [2:0] ST_Y    = 3'd4;
  localparam logic [2:0] ST_MUL2 = 3'd5;
  localparam logic [2:0] ST_WR   = 3'd6;

  logic [2:0]                          state_q, state_d;
  logic [KW-1:0]                       k_q, k_d;
  logic [CW-1:0]                       r_q, r_d;
  logic signed [SB-1:0]                x_q, x_d;
  logic [FB-1:0]                       frac_q, frac_d;
  logic signed [PW-1:0]                prod_q, prod_d;
  logic signed [SB-1:0]                y_q, y_d;
  logic [AW-1:0]                       wp_q, wp_d;
  logic                                out_valid_q, out_valid_d;
  logic [SB-1:0]                       out_data_q, out_data_d;
  logic signed [ffdl_pkg::GAIN_BITS-1:0] fb_q;

  logic                 fire_in, wr_go, rd_en;
  logic [CW-1:0]        red_sub;
  logic [AW:0]          pos_t;
  logic [AW-1:0]        idx, nxt;
  logic [FB-1:0]        fneg;
  logic signed [SB-1:0] s1, s2;
  logic signed [MA-1:0] mul_a;
  logic signed [MB-1:0] mul_b;
  logic signed [PW-1:0] mul_p, rnd_y, fbr;
  logic signed [SB+1:0] wsum;
  logic [SB-1:0]        wval;

  assign fire_in       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'(out_data_q);
  assign wr_go         = (state_q == ST_WR) && (!out_valid_q || m_axis_tready);
  assign rd_en         = (state_q == ST_ADDR);

  // one restoring step of integer delay mod DEPTH
  assign red_sub = r_q - (CW'(DEPTH) << k_q);

  // read position = write position - delay; a fraction borrows one entry
  assign pos_t = {1'b0, wp_q} - (AW + 1)'(r_q) - (AW + 1)'(frac_q != '0);
  assign idx   = pos_t[AW] ? AW'(pos_t + (AW + 1)'(DEPTH)) : AW'(pos_t);
  assign nxt   = (idx == AW'(DEPTH - 1)) ? '0 : idx + 1'b1;
  assign fneg  = '0 - frac_q;

  // shared multiplier: interpolation, then feedback
  always_comb begin
    if (state_q == ST_MUL1) begin
      mul_a = MA'(s2) - MA'(s1);
      mul_b = MB'({1'b0, fneg});
    end else begin
      mul_a = MA'(y_q);
      mul_b = MB'(fb_q);
    end
  end
  assign mul_p = PW'(mul_a) * PW'(mul_b);

  assign rnd_y = (prod_q + RND_Y) >>> FB;
  assign fbr   = (prod_q + RND_FB) >>> ffdl_pkg::GAIN_FRAC;
  assign wsum  = (SB + 2)'(x_q) + (SB + 2)'(fbr);

  always_comb begin
    if (wsum > SMAX) begin
      wval = SB'(SMAX);
    end else if (wsum < SMIN) begin
      wval = SB'(SMIN);
    end else begin
      wval = SB'(wsum);
    end
  end

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    r_d         = r_q;
    x_d         = x_q;
    frac_d      = frac_q;
    prod_d      = prod_q;
    y_d         = y_q;
    wp_d        = wp_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    unique case (state_q)
      ST_IDLE: begin
        if (fire_in) begin
          x_d     = s_axis_tdata[SB-1:0];
          frac_d  = s_axis_tdata[SB+FB-1:SB];
          r_d     = CW'(s_axis_tdata[SB+DB-1:SB+FB]);
          k_d     = KW'(KMAX);
          state_d = ST_RED;
        end
      end
      ST_RED: begin
        if (!red_sub[CW-1]) begin
          r_d = red_sub;
        end
        if (k_q == '0) begin
          state_d = ST_ADDR;
        end else begin
          k_d = k_q - 1'b1;
        end
      end
      ST_ADDR: begin
        state_d = ST_MUL1;
      end
      ST_MUL1: begin
        prod_d  = mul_p;
        state_d = ST_Y;
      end
      ST_Y: begin
        y_d     = s1 + SB'(rnd_y);
        state_d = ST_MUL2;
      end
      ST_MUL2: begin
        prod_d  = mul_p;
        state_d = ST_WR;
      end
      ST_WR: begin
        if (wr_go) begin
          out_valid_d = 1'b1;
          out_data_d  = y_q;
          wp_d        = (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      wp_q        <= '0;
      out_valid_q <= 1'b0;
      fb_q        <= '0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      wp_q        <= wp_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        fb_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    r_q        <= r_d;
    x_q        <= x_d;
    frac_q     <= frac_d;
    prod_q     <= prod_d;
    y_q        <= y_d;
    out_data_q <= out_data_d;
  end

  ffdl_store #(
    .DEPTH       (DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (rd_en),
    .rd_addr_a_i (idx),
    .rd_addr_b_i (nxt),
    .wr_en_i     (wr_go),
    .wr_addr_i   (wp_q),
    .wr_data_i   (wval),
    .rd_data_a_o (s1),
    .rd_data_b_o (s2)
  );

  `FFDL_ASSERT(a_accept_to_red, clk_i, rst_ni, fire_in |=> (state_q == ST_RED), "accept must start reduction")
  `FFDL_ASSERT(a_reduced, clk_i, rst_ni, rd_en |-> (r_q < CW'(DEPTH)), "integer delay not reduced below depth")
  `FFDL_ASSERT(a_wp_step, clk_i, rst_ni, wr_go |=> ((wp_q == '0 && $past(wp_q) == AW'(DEPTH - 1)) || (wp_q == $past(wp_q) + 1'b1)), "write position must step by one")
  `FFDL_ASSERT(a_out_after_wr, clk_i, rst_ni, $rose(m_axis_tvalid) |-> $past(state_q == ST_WR), "result shown without a store write")
  `FFDL_ASSERT_NEVER(a_no_accept_busy, clk_i, rst_ni, fire_in && (state_q != ST_IDLE), "word accepted while busy")

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for feedback_fractional_delay_line: stream words in,
// predicted interpolated taps out, compared word by word in arrival order.
// Depends on ffdl_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb;

  localparam int DEPTH     = ffdl_pkg::DEPTH_DEF;
  localparam int FRAC      = ffdl_pkg::FRACTION_BITS_DEF;
  localparam int SB        = ffdl_pkg::SAMPLE_BITS_DEF;
  localparam int DB        = ffdl_pkg::DELAY_BITS;
  localparam int GB        = ffdl_pkg::GAIN_BITS;
  localparam int IN_W      = ((SB + DB + 7) / 8) * 8;
  localparam int OUT_W     = ((SB + 7) / 8) * 8;
  localparam int STALL_MAX = 2000;
  localparam int HOLD_LEN  = 300;

  localparam logic [SB-1:0] SMP_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic [SB-1:0] SMP_MIN = {1'b1, {(SB-1){1'b0}}};

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata = '0;   // in_sample, delay_amount, zero pad
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;        // delayed_sample
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [GB-1:0]    cfg_data_i = '0;     // feedback_gain

  // predictor state
  logic signed [SB-1:0] line_mem [DEPTH];
  logic [11:0]          line_wr_pos;
  logic signed [GB-1:0] line_gain;
  logic [SB-1:0]        tap_q [$];

  int  n_errors;
  int  stall_cycles;
  bit  src_idle_en;
  bit  snk_idle_en;
  int  snk_hold_len;

  feedback_fractional_delay_line u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // One step of the delay line: read and interpolate, then write back with feedback.
  function automatic logic [SB-1:0] delay_line_step(input logic [SB-1:0] smp,
                                                    input logic [DB-1:0] dly);
    logic [DB-1:0] rd_pos;
    logic [11:0]   idx;
    logic [11:0]   nxt;
    longint        s1, s2, x, y, w;
    // read position wraps modulo DEPTH << FRAC, which is the full delay width here
    rd_pos = {line_wr_pos, {FRAC{1'b0}}} - dly;
    idx    = rd_pos[DB-1:FRAC];
    nxt    = idx + 12'd1;
    s1     = line_mem[idx];
    s2     = line_mem[nxt];
    y      = s1 + ((longint'(rd_pos[FRAC-1:0]) * (s2 - s1) + 128) >>> FRAC);
    x      = longint'($signed(smp));
    w      = x + ((longint'(line_gain) * y + 16384) >>> ffdl_pkg::GAIN_FRAC);
    if (w > longint'($signed(SMP_MAX))) w = longint'($signed(SMP_MAX));
    if (w < longint'($signed(SMP_MIN))) w = longint'($signed(SMP_MIN));
    line_mem[line_wr_pos] = w[SB-1:0];
    line_wr_pos = line_wr_pos + 12'd1;
    return y[SB-1:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [SB-1:0] got,
                                 input logic [SB-1:0] exp_val);
    $display("mismatch %s: got %h, predicted %h at %0t", what, got, exp_val, $realtime);
    n_errors++;
  endtask

  // Offer one word and hold it until accepted.
  task automatic send_word(input logic [SB-1:0] smp, input logic [DB-1:0] dly);
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {{(IN_W-SB-DB){1'b0}}, dly, smp};
    do @(posedge clk_i); while (!s_axis_tready);
    tap_q.push_back(delay_line_step(smp, dly));
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(0, 2)) @(negedge clk_i);
    end
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  // Gain writes only once the pipe has drained and the last store write has landed.
  task automatic write_gain(input logic [GB-1:0] gain);
    stop_sending();
    while (tap_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = gain;
    do @(posedge clk_i); while (!cfg_ready_o);
    line_gain = gain;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic logic [SB-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return SMP_MAX;
      1:       return SMP_MIN;
      2:       return SB'($signed($urandom_range(0, 64)) - 32);
      default: return SB'($urandom);
    endcase
  endfunction

  function automatic logic [DB-1:0] pick_delay();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return DB'($urandom_range(0, 48 << FRAC));
      6, 7:             return DB'($urandom);
      8:                return {line_wr_pos, FRAC'($urandom)};   // reads around entry 0
      default:          return {12'($urandom_range(0, 63)), {FRAC{1'b0}}};
    endcase
  endfunction

  task automatic send_random(input int n);
    repeat (n) send_word(pick_sample(), pick_delay());
  endtask

  task automatic test_directed();
    write_gain('0);
    send_word(24'h123456, 20'h00000);   // empty store, zero delay
    send_word(SMP_MAX,    20'h00000);
    send_word(SMP_MIN,    20'h00100);   // one sample back
    send_word(24'h000001, 20'h00080);   // half a sample
    send_word(24'hFFFFFF, 20'h00180);
    send_word(24'h400000, 20'h002FF);
    send_word(24'h000000, 20'hFFFFF);   // largest delay
    send_word(24'h3FFFFF, 20'h00780);   // fraction pulls the tap below entry 0
    send_word(24'hC00000, 20'h00800);   // back to entry 0 exactly
    send_word(24'h000010, 20'h00001);   // smallest fraction
    send_word(24'h7FFF00, 20'hFFF00);   // largest integer part
    send_word(24'h800001, 20'h00000);
    write_gain(16'h7FFF);               // feedback close to +1: drive into positive clip
    repeat (3) send_word(SMP_MAX, 20'h00100);
    write_gain(16'h8000);               // feedback -1: negative clip
    repeat (3) send_word(SMP_MIN, 20'h00100);
  endtask

  task automatic test_gain_sweep();
    logic [GB-1:0] gains [5];
    gains[0] = 16'h7FFF;
    gains[1] = 16'h8000;
    gains[2] = GB'($urandom);
    gains[3] = 16'h0001;
    gains[4] = 16'h4000;
    foreach (gains[i]) begin
      write_gain(gains[i]);
      send_random(270);
    end
  endtask

  // Sink holds off while the source keeps offering, so the block backs up.
  task automatic test_backpressure();
    write_gain(GB'($urandom));
    @(negedge clk_i);
    snk_hold_len = HOLD_LEN;
    send_random(40);
  endtask

  task automatic test_no_idle();
    write_gain(16'hE000);
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    send_random(420);
    stop_sending();
  endtask

  // result sink
  initial begin
    forever begin
      @(negedge clk_i);
      if (snk_hold_len != 0) begin
        m_axis_tready = 1'b0;
        repeat (snk_hold_len - 1) @(negedge clk_i);
        snk_hold_len = 0;
      end else if (snk_idle_en && $urandom_range(0, 4) == 0) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(0, 2)) @(negedge clk_i);
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    logic [SB-1:0] exp_tap;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (tap_q.size() == 0) begin
        report_mismatch("unexpected word", m_axis_tdata[SB-1:0], '0);
      end else begin
        exp_tap = tap_q.pop_front();
        if (m_axis_tdata[SB-1:0] !== exp_tap)
          report_mismatch("delayed_sample", m_axis_tdata[SB-1:0], exp_tap);
      end
    end
  end

  // watchdog on cycles with no handshake on any channel
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_MAX) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    n_errors     = 0;
    stall_cycles = 0;
    src_idle_en  = 1'b1;
    snk_idle_en  = 1'b1;
    snk_hold_len = 0;
    line_wr_pos  = '0;
    line_gain    = '0;
    foreach (line_mem[i]) line_mem[i] = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_gain_sweep();
    test_backpressure();
    test_no_idle();

    while (tap_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
